// ===== hw/rtl/lsog_pkg.sv =====
// Package for the laser scan to occupancy grid block.
// Holds grid constants, operation and state codes, configuration and
// datapath types, and the cell clamping function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsog_pkg;

    // Grid geometry.
    localparam int GRID_SIZE = 64;
    localparam int IDX_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int CELL_W    = 6;    // width of cell_x, cell_y, column_index
    localparam int WORD_W    = 64;   // width of one stored column
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Datapath widths.
    localparam int PROD_W = 32;      // Q1.14 x Q7.8 product
    localparam int SUM_W  = PROD_W + 1;
    localparam int XY_W   = 20;      // rotated and offset coordinate, Q.8
    localparam int SQ_W   = 2 * XY_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int SC_W   = XY_W + 17;
    localparam int VQ_W   = SC_W + 2;

    // Grid centre in Q.16 cells.
    localparam logic signed [VQ_W-1:0] CENTRE = VQ_W'(GRID_SIZE * 32768);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PLOT  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_COS   = 3'd0,
        CFG_ROT_SIN   = 3'd1,
        CFG_OFFSET_X  = 3'd2,
        CFG_OFFSET_Y  = 3'd3,
        CFG_CELLS_PM  = 3'd4,
        CFG_LIMIT_DSQ = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_SQ,
        S_CELL,
        S_RD,
        S_WB
    } t_state;

    typedef struct packed {
        logic signed [15:0] rot_cos;
        logic signed [15:0] rot_sin;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic        [15:0] cells_per_metre;
        logic        [31:0] limit_dist_sq;
    } t_cfg;

    // Stage enables from the sequencer to the geometry datapath.
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        logic en_sq;
        logic en_cell;
    } t_geom_ctl;

    typedef struct packed {
        logic [IDX_W-1:0] cx;
        logic [IDX_W-1:0] cy;
        logic             in_limit;
    } t_geom_res;

    // Q.16 cell coordinate to a clamped grid index.
    function automatic logic [IDX_W-1:0] to_cell(input logic signed [VQ_W-1:0] v);
        logic [VQ_W-17:0] q;
        q = v[VQ_W-1:16];
        if (v < 0) begin
            return '0;
        end else if (q > (VQ_W-16)'(GRID_SIZE - 1)) begin
            return IDX_W'(GRID_SIZE - 1);
        end else begin
            return IDX_W'(q);
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lsog_if.sv =====
// Valid/ready channel interfaces for the occupancy grid block.
// Depends on lsog_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsog_in_if;
    import lsog_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic signed [15:0]       point_x;
    logic signed [15:0]       point_y;
    logic [CELL_W-1:0]        column_index;

    modport source (output valid, output operation, output point_x, output point_y,
                    output column_index, input ready);
    modport sink   (input valid, input operation, input point_x, input point_y,
                    input column_index, output ready);
endinterface

interface lsog_out_if;
    import lsog_pkg::*;

    logic                valid;
    logic                ready;
    logic [CELL_W-1:0]   cell_x;
    logic [CELL_W-1:0]   cell_y;
    logic                cell_value;
    logic [WORD_W-1:0]   column_bits;

    modport source (output valid, output cell_x, output cell_y, output cell_value,
                    output column_bits, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input cell_value,
                    input column_bits, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lsog_geom.sv =====
// Geometry datapath: rotation, offset, distance test and cell scaling.
// Four register stages, each advanced by an enable from the sequencer.
// Depends on lsog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsog_geom (
    input  wire                  i_clk,
    input  lsog_pkg::t_geom_ctl  i_ctl,
    input  lsog_pkg::t_cfg       i_cfg,
    input  wire signed [15:0]    i_px,
    input  wire signed [15:0]    i_py,
    output lsog_pkg::t_geom_res  o_res
);
    import lsog_pkg::*;

    logic signed [PROD_W-1:0] r_pcx, r_psy, r_psx, r_pcy;
    logic signed [XY_W-1:0]   r_tx, r_ty;
    logic signed [SQ_W-1:0]   r_sqx, r_sqy;
    logic signed [SC_W-1:0]   r_vx, r_vy;
    t_geom_res                r_res;

    logic signed [SUM_W-1:0]  xr_sum, yr_sum;
    logic signed [XY_W-2:0]   xr_q, yr_q;
    logic signed [XY_W-1:0]   n_tx, n_ty;
    logic [D2_W-1:0]          d2;
    logic signed [VQ_W-1:0]   vx, vy;
    logic signed [16:0]       cpm_s;

    // Rounded rotation: add half an LSB, then floor by the top bits.
    always_comb begin
        xr_sum = SUM_W'(r_pcx) - SUM_W'(r_psy) + SUM_W'(8192);
        yr_sum = SUM_W'(r_psx) + SUM_W'(r_pcy) + SUM_W'(8192);
        xr_q   = xr_sum[SUM_W-1:14];
        yr_q   = yr_sum[SUM_W-1:14];
        n_tx   = XY_W'(xr_q) + XY_W'(i_cfg.offset_x);
        n_ty   = XY_W'(yr_q) + XY_W'(i_cfg.offset_y);
    end

    assign cpm_s = $signed({1'b0, i_cfg.cells_per_metre});

    always_comb begin
        d2 = {1'b0, r_sqx} + {1'b0, r_sqy};
        vx = VQ_W'(r_vx) + CENTRE;
        vy = CENTRE - VQ_W'(r_vy);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_pcx <= PROD_W'(i_cfg.rot_cos) * PROD_W'(i_px);
            r_psy <= PROD_W'(i_cfg.rot_sin) * PROD_W'(i_py);
            r_psx <= PROD_W'(i_cfg.rot_sin) * PROD_W'(i_px);
            r_pcy <= PROD_W'(i_cfg.rot_cos) * PROD_W'(i_py);
        end
        if (i_ctl.en_sum) begin
            r_tx <= n_tx;
            r_ty <= n_ty;
        end
        if (i_ctl.en_sq) begin
            r_sqx <= SQ_W'(r_tx) * SQ_W'(r_tx);
            r_sqy <= SQ_W'(r_ty) * SQ_W'(r_ty);
            r_vx  <= SC_W'(r_tx) * SC_W'(cpm_s);
            r_vy  <= SC_W'(r_ty) * SC_W'(cpm_s);
        end
        if (i_ctl.en_cell) begin
            r_res.cx       <= to_cell(vx);
            r_res.cy       <= to_cell(vy);
            r_res.in_limit <= (d2 <= D2_W'(i_cfg.limit_dist_sq));
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/laser_scan_to_occupancy_grid.sv =====
// Top level of the laser scan to occupancy grid block: sequencer, grid
// memory, configuration registers and result register.
// Depends on lsog_pkg, lsog_if and lsog_geom.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a GRID_SIZE by GRID_SIZE bit grid, stored as one 64-bit
// word per column in a synchronous memory, and handles one item at a time.
// A plot item runs from its input transfer to a valid result through
// four datapath stages (products, rounding and offset, squares and scaling,
// distance compare and clamping), a memory read of the column, and a
// write-back that writes the modified column back and loads the result.
// A read item runs through the memory read and then the write-back, and a
// clear or no-operation item goes straight to the write-back. The next input
// transfer is taken in the cycle after the result register is loaded; a
// result waiting in that register does not hold back the next transfer,
// only the loading of the next result. Clearing the grid needs no pass
// over the memory: every column carries a valid bit in flip-flops, clear
// and reset drop all of them, and a column whose valid bit is low reads as
// zero, so no clearing pass runs after reset. Configuration writes go straight
// into the registers and are meant to happen only while the block is idle.
module laser_scan_to_occupancy_grid (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    lsog_in_if.sink                         i_in,
    lsog_out_if.source                      o_out,
    input  wire                             i_cfg_we,
    input  wire [lsog_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [lsog_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import lsog_pkg::*;

    // Sequencer state and its decoded controls.
    t_state    r_state, n_state;
    t_geom_ctl geom_ctl;
    logic      in_ready;
    logic      rd_en;
    logic      wb_fire;
    logic      out_free;
    logic      in_xfer;

    // Configuration.
    t_cfg      r_cfg;

    // Captured input item.
    t_op                 r_op;
    logic signed [15:0]  r_px, r_py;
    logic [IDX_W-1:0]    r_col;
    logic                r_col_ok;

    // Grid memory, per-column valid bits and registered read data.
    logic [WORD_W-1:0]    mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_col_valid;
    logic [WORD_W-1:0]    r_rd_data;
    logic                 r_rd_valid;
    logic [IDX_W-1:0]     rd_addr;
    logic [WORD_W-1:0]    base_word, new_word, row_mask;

    // Result register.
    logic                r_out_valid;
    logic [CELL_W-1:0]   r_out_cx, r_out_cy;
    logic                r_out_val;
    logic [WORD_W-1:0]   r_out_bits;

    t_geom_res geom_res;

    localparam logic [CELL_W:0] GRID_LIMIT = (CELL_W + 1)'(GRID_SIZE);

    assign in_xfer  = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (t_op'(i_in.operation))
                        OP_PLOT: n_state = S_MUL;
                        OP_READ: n_state = S_RD;
                        default: n_state = S_WB;
                    endcase
                end
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_SQ;
            S_SQ:   n_state = S_CELL;
            S_CELL: n_state = S_RD;
            S_RD:   n_state = S_WB;
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Decoded controls.
    always_comb begin
        in_ready         = 1'b0;
        geom_ctl         = '0;
        rd_en            = 1'b0;
        wb_fire          = 1'b0;
        unique case (r_state)
            S_IDLE: in_ready         = 1'b1;
            S_MUL:  geom_ctl.en_mul  = 1'b1;
            S_SUM:  geom_ctl.en_sum  = 1'b1;
            S_SQ:   geom_ctl.en_sq   = 1'b1;
            S_CELL: geom_ctl.en_cell = 1'b1;
            S_RD:   rd_en            = 1'b1;
            S_WB:   wb_fire          = out_free;
            default: in_ready        = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_cos         <= 16'sd16384;
            r_cfg.rot_sin         <= 16'sd0;
            r_cfg.offset_x        <= 16'sd0;
            r_cfg.offset_y        <= 16'sd0;
            r_cfg.cells_per_metre <= 16'd2560;
            r_cfg.limit_dist_sq   <= 32'd671088;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROT_COS:   r_cfg.rot_cos         <= i_cfg_data[15:0];
                CFG_ROT_SIN:   r_cfg.rot_sin         <= i_cfg_data[15:0];
                CFG_OFFSET_X:  r_cfg.offset_x        <= i_cfg_data[15:0];
                CFG_OFFSET_Y:  r_cfg.offset_y        <= i_cfg_data[15:0];
                CFG_CELLS_PM:  r_cfg.cells_per_metre <= i_cfg_data[15:0];
                CFG_LIMIT_DSQ: r_cfg.limit_dist_sq   <= i_cfg_data[31:0];
                default:       r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Capture the item at its input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op     <= t_op'(i_in.operation);
            r_px     <= i_in.point_x;
            r_py     <= i_in.point_y;
            r_col    <= i_in.column_index[IDX_W-1:0];
            r_col_ok <= ({1'b0, i_in.column_index} < GRID_LIMIT);
        end
    end

    lsog_geom u_geom (
        .i_clk (i_clk),
        .i_ctl (geom_ctl),
        .i_cfg (r_cfg),
        .i_px  (r_px),
        .i_py  (r_py),
        .o_res (geom_res)
    );

    // A plot reads the column it lands on; a read item reads its own column.
    assign rd_addr = (r_op == OP_PLOT) ? geom_res.cx : r_col;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data  <= mem[rd_addr];
            r_rd_valid <= r_col_valid[rd_addr];
        end
    end

    // Read-modify-write of one grid bit. Items run one at a time, so the
    // write always lands before the next item issues its read.
    always_comb begin
        base_word = r_rd_valid ? r_rd_data : '0;
        row_mask  = WORD_W'(1) << geom_res.cy;
        new_word  = geom_res.in_limit ? (base_word | row_mask) : (base_word & ~row_mask);
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire && (r_op == OP_PLOT)) begin
            mem[geom_res.cx] <= new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_valid <= '0;
        end else if (wb_fire && (r_op == OP_CLEAR)) begin
            r_col_valid <= '0;
        end else if (wb_fire && (r_op == OP_PLOT)) begin
            r_col_valid[geom_res.cx] <= 1'b1;
        end
    end

    // Result register. Fields that carry no meaning for an operation are zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            r_out_cx   <= '0;
            r_out_cy   <= '0;
            r_out_val  <= 1'b0;
            r_out_bits <= '0;
            case (r_op)
                OP_PLOT: begin
                    r_out_cx  <= CELL_W'(geom_res.cx);
                    r_out_cy  <= CELL_W'(geom_res.cy);
                    r_out_val <= geom_res.in_limit;
                end
                OP_READ: begin
                    r_out_bits <= r_col_ok ? base_word : '0;
                end
                default: begin
                    r_out_bits <= '0;
                end
            endcase
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.cell_x      = r_out_cx;
    assign o_out.cell_y      = r_out_cy;
    assign o_out.cell_value  = r_out_val;
    assign o_out.column_bits = r_out_bits;

endmodule

`default_nettype wire

// ===== hw/rtl/lsog_chk.sv =====
// Port-level checker for the occupancy grid block, with its bind statement.
// Depends on the top level laser_scan_to_occupancy_grid.
`timescale 1ns / 1ps
`default_nettype none

module lsog_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_cell_value,
    input wire [63:0] i_out_column_bits
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // One item at a time: after an input transfer the block is busy.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again right after a transfer");

    // A plot result that set a cell never carries column bits.
    a_plot_no_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_cell_value) |-> (i_out_column_bits == 64'd0))
        else $error("plot result carries column bits");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_column_bits)))
        else $error("stalled result changed");

endmodule

bind laser_scan_to_occupancy_grid lsog_chk u_lsog_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_cell_value  (o_out.cell_value),
    .i_out_column_bits (o_out.column_bits)
);

`default_nettype wire
